>>> hw/rtl/rcfp_pkg.sv
package rcfp_pkg;

  // Frame layout
  localparam int FRAME_BYTES  = 32;
  localparam int NUM_WORDS    = 8;
  localparam int FRAME_WORDS  = (FRAME_BYTES / 4 > NUM_WORDS) ? NUM_WORDS : FRAME_BYTES / 4;
  localparam int FRAME_BITS   = FRAME_BYTES * 8;
  localparam int IDX_W        = $clog2(FRAME_BYTES + 1);

  // Field widths and stream packing
  localparam int DIR_W        = 3;
  localparam int WORD_W       = 32;
  localparam int OUT_FIELDS_W = DIR_W + NUM_WORDS * WORD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Byte codes
  localparam logic [7:0] START_BYTE   = 8'hA5;
  localparam logic [7:0] TRAILER_BYTE = 8'h5A;
  localparam logic [7:0] SEL_PARAM    = 8'd16;
  localparam logic [7:0] SEL_DRIVE    = 8'd17;
  localparam logic [7:0] CODE_STOP    = 8'h05;
  localparam logic [7:0] CODE_FWD     = 8'h02;
  localparam logic [7:0] CODE_BACK    = 8'h08;
  localparam logic [7:0] CODE_RIGHT   = 8'h06;
  localparam logic [7:0] CODE_LEFT    = 8'h04;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_STOP  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BACK  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd4;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

  // One result item as produced by the parser
  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic             frame_done;
    words_t           words;
  } result_t;

endpackage

>>> hw/rtl/rcfp_parser.sv
module rcfp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output rcfp_pkg::result_t     res
);
  import rcfp_pkg::*;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PARAM = 2'd1,
    MODE_DRIVE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_WAIT    = 2'd2
  } phase_t;

  mode_t                  mode, mode_next;
  phase_t                 phase, phase_next;
  logic [IDX_W-1:0]       byte_index, byte_index_next;
  logic [FRAME_BITS-1:0]  frame_sreg, frame_sreg_next;
  logic [DIR_W-1:0]       drive_code, drive_code_next;
  words_t                 tuning, tuning_next;
  logic                   done;

  function automatic logic [DIR_W-1:0] decode_drive(input logic [7:0] b);
    logic [DIR_W-1:0] d;
    case (b)
      CODE_FWD:   d = DIR_FWD;
      CODE_BACK:  d = DIR_BACK;
      CODE_RIGHT: d = DIR_RIGHT;
      CODE_LEFT:  d = DIR_LEFT;
      default:    d = DIR_STOP;
    endcase
    return d;
  endfunction

  // Work out the state after this byte
  always_comb begin
    mode_next       = mode;
    phase_next      = phase;
    byte_index_next = byte_index;
    frame_sreg_next = frame_sreg;
    drive_code_next = drive_code;
    tuning_next     = tuning;
    done            = 1'b0;

    if (rx_byte == SEL_PARAM) begin
      mode_next = MODE_PARAM;
    end else if (rx_byte == SEL_DRIVE) begin
      mode_next = MODE_DRIVE;
    end

    if (mode_next == MODE_DRIVE) begin
      drive_code_next = decode_drive(rx_byte);
    end else if (mode_next == MODE_PARAM) begin
      if (rx_byte == START_BYTE) begin
        phase_next      = PH_COLLECT;
        byte_index_next = '0;
      end else if (phase == PH_COLLECT) begin
        // Shift data in from the top: the first byte ends at the bottom
        frame_sreg_next = {rx_byte, frame_sreg[FRAME_BITS-1:8]};
        byte_index_next = byte_index + 1'b1;
        if (byte_index == IDX_W'(FRAME_BYTES - 1)) begin
          phase_next = PH_WAIT;
        end
      end else if (phase == PH_WAIT) begin
        if (rx_byte == TRAILER_BYTE) begin
          // Apply every nonzero little-endian word of the frame
          for (int w = 0; w < FRAME_WORDS; w++) begin
            if (frame_sreg[w*WORD_W +: WORD_W] != '0) begin
              tuning_next[w] = frame_sreg[w*WORD_W +: WORD_W];
            end
          end
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end else begin
        phase_next = PH_IDLE;
      end
    end
  end

  // Hold parser state, advance on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NONE;
      phase      <= PH_IDLE;
      byte_index <= '0;
      drive_code <= DIR_STOP;
      tuning     <= '0;
    end else if (step) begin
      mode       <= mode_next;
      phase      <= phase_next;
      byte_index <= byte_index_next;
      drive_code <= drive_code_next;
      tuning     <= tuning_next;
    end
  end

  // Frame data needs no reset: every byte is shifted in before it is read
  always_ff @(posedge clk) begin
    if (step) begin
      frame_sreg <= frame_sreg_next;
    end
  end

  assign res.direction  = drive_code_next;
  assign res.frame_done = done;
  assign res.words      = tuning_next;

endmodule

>>> hw/rtl/remote_command_frame_parser_unit.sv
// Channel  | Direction | Payload
// s_*      | in        | tdata[7:0] rx_byte
// m_*      | out       | tdata: direction, gain_k..offset_p; tlast: frame_done
//
// One item per cycle sustained while m_tready stays high; a result item passes
// from the input register through the parser into the result register, and a
// stall holds it in whichever register it is in.
// Each input item yields exactly one result item.
// rst is synchronous: it empties both registers, returns to no mode, stop
// direction and zero tuning words.
// A stalled m_tready holds the result; s_tready drops only once the input
// register is also full.
module remote_command_frame_parser_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [2:0] direction, [34:3] gain_k, [66:35] gain_b, [98:67] gain_i,
  // [130:99] gain_d, [162:131] offset_a, [194:163] offset_b,
  // [226:195] offset_c, [258:227] offset_p, rest zero
  output logic [rcfp_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast    // frame_done
);
  import rcfp_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  logic        step;
  result_t     res;
  result_t     out_res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  rcfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_res.words, out_res.direction};
  assign m_tlast = out_res.frame_done;

endmodule

>>> hw/rtl/rcfp_checker.sv
module rcfp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tready,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rcfp_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tlast
);
  import rcfp_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Direction stays a known drive code
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[DIR_W-1:0] <= DIR_LEFT)
    else $error("direction out of range");

  // Empty output side never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind remote_command_frame_parser_unit rcfp_checker u_rcfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
